// ===== rtl/core/cnes_pkg.sv =====
// ----------------------------------------------------------------------------
// cnes_pkg
// Shared types, constants and table functions of the chirp and hiss
// sound-effect sample generator.
// ----------------------------------------------------------------------------
package cnes_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_EFFECT = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_RATE   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // hash constants
    localparam logic [31:0] HASH_C1  = 32'h7feb352d;
    localparam logic [31:0] HASH_C2  = 32'h846ca68b;
    localparam logic [31:0] HASH_OFS = 32'd23;

    // Q1.16 constants
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [31:0] SLOW_Q16  = 32'd26214;
    localparam logic [16:0] HEAVY_Q16 = 17'd45875;
    localparam logic [16:0] LIGHT_Q16 = 17'd7864;

    localparam logic signed [63:0] PEAK_LEVEL = 64'sd14000;
    localparam logic signed [63:0] TRUNC_BIAS = (64'sd1 <<< 47) - 64'sd1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // request context ahead of the progress divider
    typedef struct packed {
        logic [15:0] idx;
        logic        last;
        logic        inr;
        logic [31:0] h1;
    } t_pre_side;

    // request context through the phase divider and sine lookup
    typedef struct packed {
        logic [16:0]        env;
        logic signed [15:0] hs;
        logic               last;
        logic               inr;
    } t_post_side;

    // tone pitch in Hz
    function automatic logic [9:0] pitch_hz(input logic [3:0] k);
        logic [9:0] hz;
        unique case (k)
            4'd0:    hz = 10'd150;
            4'd1:    hz = 10'd650;
            4'd2:    hz = 10'd95;
            4'd3:    hz = 10'd70;
            4'd4:    hz = 10'd880;
            default: hz = 10'd0;
        endcase
        return hz;
    endfunction

    // quarter-wave sine entry in Q0.15 from a Q30 angle, Taylor series
    function automatic logic [14:0] quarter_entry(input logic [63:0] xq);
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] v;
        x2  = (xq * xq) >> 30;
        acc = 64'd1 << 30;
        for (int d = 0; d < 6; d++) begin
            acc = (64'd1 << 30) - (((x2 * acc) >> 30) / TAYLOR_DIV[d]);
        end
        s = (xq * acc) >> 30;
        v = (s + (64'd1 << 14)) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

// ===== rtl/core/cnes_div.sv =====
// ----------------------------------------------------------------------------
// cnes_div
// Pipelined restoring divider: SPS quotient bits per stage, sideband
// context and valid bits travel alongside.
// ----------------------------------------------------------------------------
module cnes_div #(
    parameter int REM_W  = 16,
    parameter int STEPS  = 16,
    parameter int SPS    = 4,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [STEPS-1:0]  i_bits,
    input  logic [REM_W-1:0]  i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quot,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NST = (STEPS + SPS - 1) / SPS;

    logic [NST-1:0]    r_valid;
    logic [REM_W-1:0]  r_rem  [NST];
    logic [STEPS-1:0]  r_bits [NST];
    logic [Q_W-1:0]    r_quot [NST];
    logic [SIDE_W-1:0] r_side [NST];

    logic [NST-1:0]    w_src_valid;
    logic [REM_W-1:0]  w_src_rem  [NST];
    logic [STEPS-1:0]  w_src_bits [NST];
    logic [Q_W-1:0]    w_src_quot [NST];
    logic [SIDE_W-1:0] w_src_side [NST];

    logic [REM_W-1:0]  n_rem  [NST];
    logic [STEPS-1:0]  n_bits [NST];
    logic [Q_W-1:0]    n_quot [NST];

    // stage sources
    always_comb begin
        w_src_valid[0] = i_valid;
        w_src_rem[0]   = i_rem;
        w_src_bits[0]  = i_bits;
        w_src_quot[0]  = '0;
        w_src_side[0]  = i_side;
        for (int s = 1; s < NST; s++) begin
            w_src_valid[s] = r_valid[s-1];
            w_src_rem[s]   = r_rem[s-1];
            w_src_bits[s]  = r_bits[s-1];
            w_src_quot[s]  = r_quot[s-1];
            w_src_side[s]  = r_side[s-1];
        end
    end

    // compare and subtract steps of each stage
    always_comb begin
        logic [REM_W:0]   remx;
        logic [REM_W-1:0] rem;
        logic [STEPS-1:0] bits;
        logic [Q_W-1:0]   quot;
        for (int s = 0; s < NST; s++) begin
            rem  = w_src_rem[s];
            bits = w_src_bits[s];
            quot = w_src_quot[s];
            for (int k = 0; k < SPS; k++) begin
                if (s * SPS + k < STEPS) begin
                    remx = {rem, bits[STEPS-1]};
                    bits = bits << 1;
                    if (remx >= {1'b0, i_divisor}) begin
                        remx = remx - {1'b0, i_divisor};
                        quot = {quot[Q_W-2:0], 1'b1};
                    end else begin
                        quot = {quot[Q_W-2:0], 1'b0};
                    end
                    rem = remx[REM_W-1:0];
                end
            end
            n_rem[s]  = rem;
            n_bits[s] = bits;
            n_quot[s] = quot;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= w_src_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NST; s++) begin
                r_rem[s]  <= n_rem[s];
                r_bits[s] <= n_bits[s];
                r_quot[s] <= n_quot[s];
                r_side[s] <= w_src_side[s];
            end
        end
    end

    assign o_valid = r_valid[NST-1];
    assign o_quot  = r_quot[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ===== rtl/core/cnes_sine.sv =====
// ----------------------------------------------------------------------------
// cnes_sine
// Phase to Q1.15 sine: table position, quadrant fold, registered
// quarter-wave table read and sign.
// ----------------------------------------------------------------------------
module cnes_sine #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SIDE_W           = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_phase,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic signed [15:0]  o_sine,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int POS_W = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int A_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PRD_W = 33 + POS_W;

    localparam logic [POS_W:0]   FOUR_D = (POS_W + 1)'(4 * SINE_TABLE_DEPTH);
    localparam logic [POS_W-1:0] D1     = POS_W'(SINE_TABLE_DEPTH);
    localparam logic [POS_W-1:0] D2     = POS_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [POS_W-1:0] D3     = POS_W'(3 * SINE_TABLE_DEPTH);

    // quarter-wave table
    logic [14:0] w_rom [SINE_TABLE_DEPTH + 1];

    for (genvar j = 0; j <= SINE_TABLE_DEPTH; j++) begin : g_rom
        localparam logic [63:0] XQ = (cnes_pkg::HALF_PI_Q30 * 64'(j)) / SINE_TABLE_DEPTH;
        assign w_rom[j] = cnes_pkg::quarter_entry(XQ);
    end

    logic [2:0]        r_valid;
    logic [POS_W-1:0]  r_pos;
    logic [A_W-1:0]    r_addr;
    logic              r_neg_a;
    logic              r_neg_b;
    logic [14:0]       r_sine;
    logic [SIDE_W-1:0] r_side [3];

    logic [PRD_W-1:0] w_prod;
    logic [POS_W-1:0] w_base;
    logic [1:0]       w_quad;
    logic [POS_W-1:0] w_r;
    logic [A_W-1:0]   n_addr;

    // table position from phase
    assign w_prod = PRD_W'(i_phase) * PRD_W'(FOUR_D);

    // quadrant fold
    always_comb begin
        priority if (r_pos >= D3) begin
            w_quad = 2'd3;
            w_base = D3;
        end else if (r_pos >= D2) begin
            w_quad = 2'd2;
            w_base = D2;
        end else if (r_pos >= D1) begin
            w_quad = 2'd1;
            w_base = D1;
        end else begin
            w_quad = 2'd0;
            w_base = '0;
        end
        w_r = r_pos - w_base;
        if (w_quad[0]) begin
            n_addr = A_W'(D1 - w_r);
        end else begin
            n_addr = A_W'(w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos     <= w_prod[32 +: POS_W];
            r_addr    <= n_addr;
            r_neg_a   <= w_quad[1];
            r_sine    <= w_rom[r_addr];
            r_neg_b   <= r_neg_a;
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
        end
    end

    assign o_valid = r_valid[2];
    assign o_sine  = r_neg_b ? -signed'({1'b0, r_sine}) : signed'({1'b0, r_sine});
    assign o_side  = r_side[2];

endmodule

// ===== rtl/core/chirp_noise_effect_synth.sv =====
// Throughput: one request per cycle; every stage advances together while the
// output register is empty or being taken.
// The progress and phase dividers (four or five quotient bits per stage) set the depth.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// chirp_noise_effect_synth
// Sound-effect sample generator: sine chirp mixed with hashed hiss under a
// quadratic decay envelope.
// ----------------------------------------------------------------------------
module chirp_noise_effect_synth #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int TONE_COUNT       = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cnes_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cnes_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [15:0]                         i_sample_index,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [14:0]                  o_sample_value,
    output logic                                o_last_sample
);

    localparam int PRE_W  = $bits(cnes_pkg::t_pre_side);
    localparam int POST_W = $bits(cnes_pkg::t_post_side);

    // pitch per effect number
    logic [9:0] w_hz_tab [256];

    for (genvar e = 0; e < 256; e++) begin : g_hz
        localparam int K = e % TONE_COUNT;
        assign w_hz_tab[e] = cnes_pkg::pitch_hz(4'(K));
    end

    // configuration
    logic        r_heavy;
    logic [9:0]  r_hz;
    logic [15:0] r_count;
    logic [17:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heavy <= 1'b1;
            r_hz    <= w_hz_tab[0];
            r_count <= 16'd4096;
            r_rate  <= 18'd22050;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cnes_pkg::CFG_EFFECT: begin
                    r_heavy <= (i_cfg_wdata[7:0] == 8'd0);
                    r_hz    <= w_hz_tab[i_cfg_wdata[7:0]];
                end
                cnes_pkg::CFG_COUNT: r_count <= i_cfg_wdata[15:0];
                cnes_pkg::CFG_RATE:  r_rate  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic w_adv;
    logic r_out_valid;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = w_adv;

    // input stage: range check, last flag, first hash mix
    logic        r_s1_valid;
    logic [15:0] r_s1_idx;
    logic        r_s1_last;
    logic        r_s1_inr;
    logic [31:0] r_s1_h1;
    logic [31:0] w_hv;

    assign w_hv = 32'(i_sample_index) + cnes_pkg::HASH_OFS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_idx  <= i_sample_index;
            r_s1_last <= (r_count != 16'd0) && (i_sample_index == r_count - 16'd1);
            r_s1_inr  <= (i_sample_index < r_count);
            r_s1_h1   <= w_hv ^ (w_hv >> 16);
        end
    end

    // progress divider
    cnes_pkg::t_pre_side w_pre_in;
    cnes_pkg::t_pre_side w_pre_out;
    logic [PRE_W-1:0]    w_pre_out_v;
    logic                w_pdiv_valid;
    logic [15:0]         w_prog;

    assign w_pre_in.idx  = r_s1_idx;
    assign w_pre_in.last = r_s1_last;
    assign w_pre_in.inr  = r_s1_inr;
    assign w_pre_in.h1   = r_s1_h1;
    assign w_pre_out     = w_pre_out_v;

    cnes_div #(
        .REM_W  (16),
        .STEPS  (16),
        .SPS    (4),
        .Q_W    (16),
        .SIDE_W (PRE_W)
    ) u_prog_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_valid   (r_s1_valid),
        .i_rem     (r_s1_idx),
        .i_bits    (16'd0),
        .i_divisor (r_count),
        .i_side    (w_pre_in),
        .o_valid   (w_pdiv_valid),
        .o_quot    (w_prog),
        .o_side    (w_pre_out_v)
    );

    // stage a: envelope base, slowdown, pitch times index, hash multiply
    logic        r_a_valid;
    logic [16:0] r_a_om;
    logic [16:0] r_a_slow;
    logic [25:0] r_a_hzidx;
    logic [31:0] r_a_hm;
    logic        r_a_last;
    logic        r_a_inr;
    logic [31:0] w_slow_prod;
    logic [63:0] w_hm_prod;

    assign w_slow_prod = 32'(w_prog) * cnes_pkg::SLOW_Q16;
    assign w_hm_prod   = 64'(w_pre_out.h1) * 64'(cnes_pkg::HASH_C1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_pdiv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_om    <= cnes_pkg::ONE_Q16 - 17'(w_prog);
            r_a_slow  <= cnes_pkg::ONE_Q16 - 17'(w_slow_prod >> 16);
            r_a_hzidx <= 26'(r_hz) * 26'(w_pre_out.idx);
            r_a_hm    <= w_hm_prod[31:0];
            r_a_last  <= w_pre_out.last;
            r_a_inr   <= w_pre_out.inr;
        end
    end

    // stage b: envelope, phase numerator, second hash multiply
    logic        r_b_valid;
    logic [16:0] r_b_env;
    logic [42:0] r_b_p;
    logic [31:0] r_b_h4;
    logic        r_b_last;
    logic        r_b_inr;
    logic [33:0] w_env_prod;
    logic [31:0] w_h3;
    logic [63:0] w_h4_prod;

    assign w_env_prod = 34'(r_a_om) * 34'(r_a_om);
    assign w_h3       = r_a_hm ^ (r_a_hm >> 15);
    assign w_h4_prod  = 64'(w_h3) * 64'(cnes_pkg::HASH_C2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_env  <= w_env_prod[32:16];
            r_b_p    <= 43'(r_a_hzidx) * 43'(r_a_slow);
            r_b_h4   <= w_h4_prod[31:0];
            r_b_last <= r_a_last;
            r_b_inr  <= r_a_inr;
        end
    end

    // phase divider
    cnes_pkg::t_post_side w_post_in;
    cnes_pkg::t_post_side w_post_mid;
    logic [POST_W-1:0]    w_post_mid_v;
    logic [15:0]          w_noise;
    logic                 w_fdiv_valid;
    logic [31:0]          w_quot;
    logic [31:0]          w_phase;

    assign w_noise        = r_b_h4[15:0] ^ r_b_h4[31:16];
    assign w_post_in.env  = r_b_env;
    assign w_post_in.hs   = signed'({~w_noise[15], w_noise[14:0]});
    assign w_post_in.last = r_b_last;
    assign w_post_in.inr  = r_b_inr;
    assign w_post_mid     = w_post_mid_v;

    cnes_div #(
        .REM_W  (18),
        .STEPS  (59),
        .SPS    (5),
        .Q_W    (32),
        .SIDE_W (POST_W)
    ) u_phase_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_valid   (r_b_valid),
        .i_rem     (18'd0),
        .i_bits    ({r_b_p, 16'd0}),
        .i_divisor (r_rate),
        .i_side    (w_post_in),
        .o_valid   (w_fdiv_valid),
        .o_quot    (w_quot),
        .o_side    (w_post_mid_v)
    );

    // zero rate holds the phase at zero
    assign w_phase = (r_rate == 18'd0) ? 32'd0 : w_quot;

    // sine lookup
    cnes_pkg::t_post_side w_post_out;
    logic [POST_W-1:0]    w_post_out_v;
    logic                 w_sine_valid;
    logic signed [15:0]   w_tn;

    assign w_post_out = w_post_out_v;

    cnes_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SIDE_W           (POST_W)
    ) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_fdiv_valid),
        .i_phase (w_phase),
        .i_side  (w_post_mid),
        .o_valid (w_sine_valid),
        .o_sine  (w_tn),
        .o_side  (w_post_out_v)
    );

    // stage g: weighted tone and hiss
    logic               r_g_valid;
    logic signed [33:0] r_g_t1;
    logic signed [33:0] r_g_t2;
    logic [16:0]        r_g_env;
    logic               r_g_last;
    logic               r_g_inr;
    logic [16:0]        w_mix;
    logic [16:0]        w_tone_wt;

    assign w_mix     = r_heavy ? cnes_pkg::HEAVY_Q16 : cnes_pkg::LIGHT_Q16;
    assign w_tone_wt = cnes_pkg::ONE_Q16 - w_mix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (w_adv) begin
            r_g_valid <= w_sine_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_t1   <= 34'(w_tn) * 34'(signed'({1'b0, w_tone_wt}));
            r_g_t2   <= 34'(w_post_out.hs) * 34'(signed'({1'b0, w_mix}));
            r_g_env  <= w_post_out.env;
            r_g_last <= w_post_out.last;
            r_g_inr  <= w_post_out.inr;
        end
    end

    // stage h: blend
    logic               r_h_valid;
    logic signed [33:0] r_h_acc;
    logic [16:0]        r_h_env;
    logic               r_h_last;
    logic               r_h_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (w_adv) begin
            r_h_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h_acc  <= r_g_t1 + r_g_t2;
            r_h_env  <= r_g_env;
            r_h_last <= r_g_last;
            r_h_inr  <= r_g_inr;
        end
    end

    // stage i: envelope times blend
    logic               r_i_valid;
    logic signed [51:0] r_i_ea;
    logic               r_i_last;
    logic               r_i_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (w_adv) begin
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_i_ea   <= 52'(signed'({1'b0, r_h_env})) * 52'(r_h_acc);
            r_i_last <= r_h_last;
            r_i_inr  <= r_h_inr;
        end
    end

    // stage j: peak level scaling
    logic               r_j_valid;
    logic signed [63:0] r_j_big;
    logic               r_j_last;
    logic               r_j_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
        end else if (w_adv) begin
            r_j_valid <= r_i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_j_big  <= 64'(r_i_ea) * cnes_pkg::PEAK_LEVEL;
            r_j_last <= r_i_last;
            r_j_inr  <= r_i_inr;
        end
    end

    // output register: shift down by 47 with truncation toward zero
    logic signed [63:0] w_round;
    logic signed [63:0] w_res;
    logic signed [14:0] r_out_value;
    logic               r_out_last;

    assign w_round = (r_j_big < 64'sd0) ? (r_j_big + cnes_pkg::TRUNC_BIAS) : r_j_big;
    assign w_res   = w_round >>> 47;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_j_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_value <= r_j_inr ? w_res[14:0] : 15'sd0;
            r_out_last  <= r_j_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_last_sample  = r_out_last;

`ifndef ASSERT_OFF
    // an empty output register always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("output register empty but not ready");

    // sample magnitude stays within the peak level
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_value <= 15'sd14000 && o_sample_value >= -15'sd14000))
        else $error("sample beyond peak level");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sample_value) && $stable(o_last_sample)))
        else $error("stalled result changed");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule
